// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Word layouts, operation codes, field widths and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Operand width of each fraction term
  localparam int OPERAND_WIDTH = 16;

  // Exact product and sum widths
  localparam int PROD_W  = 2 * OPERAND_WIDTH;
  localparam int MAG_W   = PROD_W + 1;
  localparam int SHIFT_W = $clog2(MAG_W + 1);
  localparam int CNT_W   = $clog2(MAG_W);

  // Result field widths
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;

  // Operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Multiplier step selects
  localparam logic [1:0] MSTEP_NUM  = 2'd0;
  localparam logic [1:0] MSTEP_TERM = 2'd1;
  localparam logic [1:0] MSTEP_DEN  = 2'd2;

  typedef struct packed {
    logic [1:0]                      operation;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
  } rau_req_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] result_num;
    logic [DEN_W-1:0]        result_den;
    logic                    error;
  } rau_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul;
    logic [1:0] mstep;
    logic       add;
    logic       gcd_init;
    logic       gcd_step;
    logic       gcd_shift;
    logic       div_step;
    logic       out_write;
  } rau_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic addsub;
    logic both_zero;
    logic gcd_done;
  } rau_sts_t;

endpackage

// ===== rtl/rational_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top: rational fraction arithmetic with reduction
//
//   channel   port                   word        direction
//   request   req_valid/req_ready    rau_req_t   into the block
//   response  rsp_valid/rsp_ready    rau_rsp_t   out of the block
//
// One word is in flight at a time. After the accept cycle a word passes the
// numerator and denominator multiplies (plus a cross-term multiply and a
// combine step for add and subtract), a GCD setup step, the binary GCD loop
// and its exit, a shift step, bit-serial division and a final write; zero over
// zero goes from the GCD loop to the write. The final write waits while the
// previous result is still held. The response register frees the engine, so
// a new word is taken while the previous result still waits. Reset is
// synchronous and clears only the controller; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  rau_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output rau_rsp_t rsp
);

  rau_cmd_t cmd;
  rau_sts_t sts;

  // Sequence the work
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Compute and reduce
  rau_dp u_dp (
    .clk (clk),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// ===== rtl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Steps one word through multiply, combine, binary GCD and exact division,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  rau_sts_t sts,
  output rau_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL0   = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_MUL2   = 4'd3;
  localparam logic [3:0] S_ADD    = 4'd4;
  localparam logic [3:0] S_GINIT  = 4'd5;
  localparam logic [3:0] S_GCD    = 4'd6;
  localparam logic [3:0] S_GSHIFT = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // Next state and command strobes
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul    = 1'b1;
        cmd.mstep  = MSTEP_NUM;
        state_next = sts.addsub ? S_MUL1 : S_MUL2;
      end
      S_MUL1: begin
        cmd.mul    = 1'b1;
        cmd.mstep  = MSTEP_TERM;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul    = 1'b1;
        cmd.mstep  = MSTEP_DEN;
        state_next = sts.addsub ? S_ADD : S_GINIT;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_GINIT;
      end
      S_GINIT: begin
        cmd.gcd_init = 1'b1;
        state_next   = S_GCD;
      end
      S_GCD: begin
        if (sts.both_zero) begin
          state_next = S_FIN;
        end else if (sts.gcd_done) begin
          state_next = S_GSHIFT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_GSHIFT: begin
        cmd.gcd_shift = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_write = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count division steps
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == S_DIV) begin
      cnt <= cnt + CNT_W'(1);
    end else begin
      cnt <= '0;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_write) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Sign-magnitude operands, one shared multiplier, a magnitude adder, a binary
// GCD unit and two bit-serial dividers that reduce numerator and denominator.
// ----------------------------------------------------------------------------
module rau_dp import rau_pkg::*; (
  input  logic     clk,
  input  rau_req_t req,
  input  rau_cmd_t cmd,
  output rau_sts_t sts,
  output rau_rsp_t rsp
);

  localparam int W    = OPERAND_WIDTH;
  localparam int NX_W = (MAG_W > NUM_W) ? MAG_W : NUM_W;
  localparam int DX_W = (MAG_W > DEN_W) ? MAG_W : DEN_W;

  logic [1:0]         op;
  logic [W-1:0]       an_mag, ad_mag, bn_mag, bd_mag;
  logic               an_neg, ad_neg, bn_neg, bd_neg;
  logic [MAG_W-1:0]   num_mag;
  logic               num_neg;
  logic [PROD_W-1:0]  t_mag;
  logic               t_neg;
  logic [PROD_W-1:0]  den_mag;
  logic               den_neg;
  logic [MAG_W-1:0]   u, v, g;
  logic [SHIFT_W-1:0] k;
  logic [MAG_W-1:0]   rem_n, rem_d, quo_n, quo_d;

  logic [W-1:0]       mul_x, mul_y;
  logic               mul_sx, mul_sy;
  logic [PROD_W-1:0]  prod;
  logic               prod_neg;
  logic [MAG_W-1:0]   t_ext, sum_mag;
  logic               sum_neg;
  logic [MAG_W:0]     trial_n, trial_d;
  logic               take_n, take_d;
  logic [NX_W-1:0]    qn_x;
  logic [DX_W-1:0]    qd_x;
  logic [NUM_W-1:0]   qn_fit;
  logic               res_neg;

  // Capture operand magnitudes and signs
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= req.operation;
      an_neg <= req.a_num[W-1];
      ad_neg <= req.a_den[W-1];
      bn_neg <= req.b_num[W-1];
      bd_neg <= req.b_den[W-1];
      an_mag <= req.a_num[W-1] ? W'(-req.a_num) : W'(req.a_num);
      ad_mag <= req.a_den[W-1] ? W'(-req.a_den) : W'(req.a_den);
      bn_mag <= req.b_num[W-1] ? W'(-req.b_num) : W'(req.b_num);
      bd_mag <= req.b_den[W-1] ? W'(-req.b_den) : W'(req.b_den);
    end
  end

  assign sts.addsub = (op == OP_ADD) || (op == OP_SUB);

  // Select multiplier operands for each step
  always_comb begin
    case (cmd.mstep)
      MSTEP_NUM: begin
        mul_x  = an_mag;
        mul_sx = an_neg;
        mul_y  = (op == OP_MUL) ? bn_mag : bd_mag;
        mul_sy = (op == OP_MUL) ? bn_neg : bd_neg;
      end
      MSTEP_TERM: begin
        mul_x  = bn_mag;
        mul_sx = bn_neg;
        mul_y  = ad_mag;
        mul_sy = ad_neg;
      end
      default: begin
        mul_x  = ad_mag;
        mul_sx = ad_neg;
        mul_y  = (op == OP_DIV) ? bn_mag : bd_mag;
        mul_sy = (op == OP_DIV) ? bn_neg : bd_neg;
      end
    endcase
    prod     = PROD_W'(mul_x) * PROD_W'(mul_y);
    prod_neg = (prod != '0) && (mul_sx != mul_sy);
  end

  // Combine the two cross terms in sign-magnitude form
  always_comb begin
    t_ext = MAG_W'(t_mag);
    if (num_neg == t_neg) begin
      sum_mag = num_mag + t_ext;
      sum_neg = num_neg;
    end else if (num_mag >= t_ext) begin
      sum_mag = num_mag - t_ext;
      sum_neg = num_neg;
    end else begin
      sum_mag = t_ext - num_mag;
      sum_neg = t_neg;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  // Hold raw numerator and denominator
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      case (cmd.mstep)
        MSTEP_NUM: begin
          num_mag <= MAG_W'(prod);
          num_neg <= prod_neg;
        end
        MSTEP_TERM: begin
          t_mag <= prod;
          t_neg <= (op == OP_SUB) ? (prod_neg ^ (prod != '0)) : prod_neg;
        end
        default: begin
          den_mag <= prod;
          den_neg <= prod_neg;
        end
      endcase
    end else if (cmd.add) begin
      num_mag <= sum_mag;
      num_neg <= sum_neg;
    end
  end

  assign sts.both_zero = (num_mag == '0) && (den_mag == '0);
  assign sts.gcd_done  = (u == '0) || (v == '0);

  // Binary GCD: one reduction per cycle, common factors of two counted in k
  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      u <= num_mag;
      v <= MAG_W'(den_mag);
      k <= '0;
    end else if (cmd.gcd_step) begin
      if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + SHIFT_W'(1);
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u >= v) begin
        u <= (u - v) >> 1;
      end else begin
        v <= (v - u) >> 1;
      end
    end
  end

  // Restore the factors of two into the divisor
  always_ff @(posedge clk) begin
    if (cmd.gcd_shift) begin
      g <= (u | v) << k;
    end
  end

  // Restoring division of both magnitudes by the GCD, one bit per cycle
  assign trial_n = {rem_n, quo_n[MAG_W-1]};
  assign trial_d = {rem_d, quo_d[MAG_W-1]};
  assign take_n  = (trial_n >= {1'b0, g});
  assign take_d  = (trial_d >= {1'b0, g});

  always_ff @(posedge clk) begin
    if (cmd.gcd_shift) begin
      rem_n <= '0;
      rem_d <= '0;
      quo_n <= num_mag;
      quo_d <= MAG_W'(den_mag);
    end else if (cmd.div_step) begin
      rem_n <= take_n ? MAG_W'(trial_n - {1'b0, g}) : MAG_W'(trial_n);
      rem_d <= take_d ? MAG_W'(trial_d - {1'b0, g}) : MAG_W'(trial_d);
      quo_n <= {quo_n[MAG_W-2:0], take_n};
      quo_d <= {quo_d[MAG_W-2:0], take_d};
    end
  end

  // Fit quotients to the result fields and apply the sign
  assign qn_x    = NX_W'(quo_n);
  assign qd_x    = DX_W'(quo_d);
  assign qn_fit  = qn_x[NUM_W-1:0];
  assign res_neg = (num_neg != den_neg) && (num_mag != '0) && (den_mag != '0);

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      if (sts.both_zero) begin
        rsp.result_num <= '0;
        rsp.result_den <= '0;
        rsp.error      <= 1'b1;
      end else begin
        rsp.result_num <= res_neg ? -qn_fit : qn_fit;
        rsp.result_den <= qd_x[DEN_W-1:0];
        rsp.error      <= 1'b0;
      end
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the rational arithmetic unit
// Sends fraction pairs with all four operations (a short directed set of
// extremes, zero numerators, zero denominators and zero over zero, then
// random words), predicts each reduced fraction with 64-bit integer math and
// compares every response word in order. The sender works in bursts with
// random gaps; the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb;
  import rau_pkg::*;

  localparam int RANDOM_WORDS   = 450;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int REPORT_LIMIT   = 10;

  localparam logic signed [OPERAND_WIDTH-1:0] MIN_OPERAND =
    {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
  localparam logic signed [OPERAND_WIDTH-1:0] MAX_OPERAND =
    {1'b0, {(OPERAND_WIDTH-1){1'b1}}};

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MASKED,
    READY_SPARSE,
    READY_RANDOM
  } ready_mode_e;

  // Reduced-fraction predictor and in-order store of expected responses
  class fraction_checker;
    rau_rsp_t pending_fractions[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    function rau_rsp_t reduce_fraction(rau_req_t w);
      longint an, ad, bn, bd, top, bottom, mag_top, mag_bottom, x, y, t, qn, qd;
      rau_rsp_t r;
      an     = longint'(w.a_num);
      ad     = longint'(w.a_den);
      bn     = longint'(w.b_num);
      bd     = longint'(w.b_den);
      top    = 0;
      bottom = 0;
      r      = '0;
      case (w.operation)
        OP_ADD: begin
          top    = an * bd + bn * ad;
          bottom = ad * bd;
        end
        OP_SUB: begin
          top    = an * bd - bn * ad;
          bottom = ad * bd;
        end
        OP_MUL: begin
          top    = an * bn;
          bottom = ad * bd;
        end
        OP_DIV: begin
          top    = an * bd;
          bottom = ad * bn;
        end
      endcase
      mag_top    = (top < 0) ? -top : top;
      mag_bottom = (bottom < 0) ? -bottom : bottom;
      // Euclid on the raw magnitudes
      x = mag_top;
      y = mag_bottom;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      // Zero over zero has no divisor: flag it
      if (x == 0) begin
        r.error = 1'b1;
        return r;
      end
      qn = mag_top / x;
      qd = mag_bottom / x;
      if ((top < 0) != (bottom < 0) && top != 0 && bottom != 0)
        qn = -qn;
      r.result_num = qn[NUM_W-1:0];
      r.result_den = qd[DEN_W-1:0];
      return r;
    endfunction

    function void note_request(rau_req_t w);
      pending_fractions.push_back(reduce_fraction(w));
    endfunction

    function void check_result(rau_rsp_t got);
      rau_rsp_t want;
      if (pending_fractions.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: response word with nothing outstanding: num %0d den %0d err %0b",
                   $realtime, got.result_num, got.result_den, got.error);
        return;
      end
      want = pending_fractions.pop_front();
      if (got.result_num !== want.result_num || got.result_den !== want.result_den ||
          got.error !== want.error) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch: expected num %0d den %0d err %0b, got num %0d den %0d err %0b",
                   $realtime, want.result_num, want.result_den, want.error,
                   got.result_num, got.result_den, got.error);
      end
    endfunction

    function int outstanding();
      return pending_fractions.size();
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  rau_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  rau_rsp_t rsp;

  fraction_checker sb;
  int              idle_cycles;
  int              burst_left;
  ready_mode_e     ready_mode;
  logic [15:0]     ready_mask;
  logic [3:0]      ready_phase;
  int              ready_hold;

  rational_arithmetic_unit_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver stall pattern: switch mode whenever a random hold count runs out
  always @(posedge clk) begin
    if (rst) begin
      ready_mode  <= READY_ALWAYS;
      ready_mask  <= '1;
      ready_phase <= '0;
      ready_hold  <= 0;
      rsp_ready   <= 1'b0;
    end else begin
      if (ready_hold == 0) begin
        ready_mode <= ready_mode_e'($urandom_range(0, 3));
        ready_mask <= 16'($urandom);
        ready_hold <= $urandom_range(20, 120);
      end else begin
        ready_hold <= ready_hold - 1;
      end
      case (ready_mode)
        READY_ALWAYS: rsp_ready <= 1'b1;
        READY_MASKED: rsp_ready <= ready_mask[ready_phase];
        READY_SPARSE: rsp_ready <= (ready_phase[1:0] == 2'd0);
        default:      rsp_ready <= 1'($urandom_range(0, 1));
      endcase
      ready_phase <= ready_phase + 1'b1;
    end
  end

  // Monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rsp_valid && rsp_ready)
        sb.check_result(rsp);
      if (req_valid && req_ready)
        sb.note_request(req);
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one word and hold it until accepted
  task automatic send_word(input rau_req_t w);
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Continue the burst or drop valid for a random gap
  task automatic pace_sender();
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 10);
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 5);
        2: gap = $urandom_range(10, 60);
        default: gap = $urandom_range(80, 140);
      endcase
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fraction(input logic [1:0] op,
                               input logic signed [OPERAND_WIDTH-1:0] an,
                               input logic signed [OPERAND_WIDTH-1:0] ad,
                               input logic signed [OPERAND_WIDTH-1:0] bn,
                               input logic signed [OPERAND_WIDTH-1:0] bd);
    rau_req_t w;
    w.operation = op;
    w.a_num     = an;
    w.a_den     = ad;
    w.b_num     = bn;
    w.b_den     = bd;
    send_word(w);
    pace_sender();
  endtask

  // Mix of full-range, small and corner operands
  function automatic logic signed [OPERAND_WIDTH-1:0] pick_operand();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4)
      return OPERAND_WIDTH'($urandom);
    if (kind < 7)
      return OPERAND_WIDTH'($urandom_range(0, 16) - 8);
    case ($urandom_range(0, 5))
      0: return MIN_OPERAND;
      1: return OPERAND_WIDTH'(MIN_OPERAND + 1);
      2: return MAX_OPERAND;
      3: return OPERAND_WIDTH'(-1);
      4: return OPERAND_WIDTH'(1);
      default: return OPERAND_WIDTH'(0);
    endcase
  endfunction

  initial begin
    sb         = new();
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: plain cases of each operation
    send_fraction(OP_ADD, 1, 2, 1, 3);
    send_fraction(OP_SUB, 1, 3, 1, 2);
    send_fraction(OP_MUL, 2, 3, 9, 4);
    send_fraction(OP_DIV, 3, 4, 9, 8);
    // Zero numerator reduces to 0/1
    send_fraction(OP_SUB, 1, 2, 1, 2);
    send_fraction(OP_MUL, 0, 7, 5, -3);
    // Zero denominator with nonzero numerator gives 1/0
    send_fraction(OP_DIV, 3, 4, 0, 5);
    send_fraction(OP_ADD, -5, 0, 3, 7);
    // Zero over zero raises the error flag
    send_fraction(OP_MUL, 0, 0, 5, 7);
    send_fraction(OP_ADD, 0, 0, 0, 0);
    send_fraction(OP_DIV, 0, 3, 0, 9);
    // Negative denominators
    send_fraction(OP_ADD, 1, -2, 0, -3);
    send_fraction(OP_DIV, -7, -9, 14, -3);
    // Operand extremes
    send_fraction(OP_ADD, MIN_OPERAND, MIN_OPERAND, MIN_OPERAND, MIN_OPERAND);
    send_fraction(OP_SUB, MIN_OPERAND, MAX_OPERAND, MAX_OPERAND, MIN_OPERAND);
    send_fraction(OP_MUL, MIN_OPERAND, 1, MIN_OPERAND, 1);
    send_fraction(OP_DIV, MAX_OPERAND, MIN_OPERAND, MIN_OPERAND, MAX_OPERAND);
    send_fraction(OP_ADD, MAX_OPERAND, 1, MAX_OPERAND, 1);
    send_fraction(OP_SUB, MIN_OPERAND, MAX_OPERAND, MAX_OPERAND,
                  OPERAND_WIDTH'(MAX_OPERAND - 1));
    send_fraction(OP_ADD, MIN_OPERAND, MAX_OPERAND, MIN_OPERAND,
                  OPERAND_WIDTH'(MAX_OPERAND - 2));
    send_fraction(OP_MUL, MAX_OPERAND, OPERAND_WIDTH'(MIN_OPERAND + 1), -1, MAX_OPERAND);
    send_fraction(OP_DIV, -1, MIN_OPERAND, MIN_OPERAND, -1);

    // Random words
    for (int i = 0; i < RANDOM_WORDS; i++)
      send_fraction(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                    pick_operand(), pick_operand());
    req_valid <= 1'b0;

    // Drain outstanding responses, then let the engine settle
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
